// ===== hw/rtl/tcetq_pkg.sv =====
// Package for the expiry timer queue.
// Result codes, command codes and sizes; no dependencies.
package tcetq_pkg;
   localparam int unsigned ENTRIES   = 32;
   localparam int unsigned SLOT_W    = 5;

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;
   localparam logic [1:0] KIND_WAKE   = 2'd3;

   localparam logic [1:0] RES_FIRED   = 2'd0;
   localparam logic [1:0] RES_ARM     = 2'd1;
   localparam logic [1:0] RES_CANCEL  = 2'd2;
   localparam logic [1:0] RES_NOTHING = 2'd3;

   localparam logic [0:0] CSR_OFFSET  = 1'b0;
   localparam logic [0:0] CSR_VALID   = 1'b1;

   // stored entry, one word per slot
   typedef struct packed {
      logic [31:0] tim;
      logic        loc;
      logic        wake;
      logic [15:0] order;
   } slot_type;

   // saturate a 34-bit signed sum to 0 .. 2^32-1
   function automatic logic [31:0] sat32(input logic signed [33:0] v);
      logic [31:0] r;
      if (v < 0) r = '0;
      else if (v[33:32] != 2'b00) r = '1;
      else r = v[31:0];
      return r;
   endfunction
endpackage

// ===== hw/rtl/two_clock_expiry_timer_queue.sv =====
// Top level of the expiry timer queue.
// Slot store in one synchronous memory plus a scan sequencer; uses tcetq_pkg.
//
// A transaction is taken when start is high and busy low. busy falls in the cycle
// that presents the last result. Results appear at most one per cycle with
// rsp_valid for a single cycle and cannot be stalled. The final result of a
// transaction carries rsp_last, and a transaction with no effect gives one
// "nothing" result. Slot data live in a memory read one slot per cycle, and each
// scan but the count scan is followed by a step that acts on it.
// - Head check: an add scans all slots once, and a remove first reads its own
//   slot, then sweeps all slots.
// - Update: it scans once to count queues. It then scans once per fired entry,
//   plus once for each queue popped, and once per timer class.
// - A tick with nothing due makes the count scan, a pop scan and the class scans,
//   and one scan more when the local offset is valid. Each fired entry adds a scan.
// - With no UTC entry, and no local entry or no valid offset: count scan, then cancels.
// Slot valid bits are flip-flops cleared at reset: no clearing pass.
// Configuration writes are taken at any time and should be made while idle.
module two_clock_expiry_timer_queue
   import tcetq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [4:0]  req_entry,
   input  logic [31:0] req_start_time,
   input  logic        req_is_local,
   input  logic        req_needs_wake,
   input  logic [31:0] req_now,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [16:0] csr_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind_res,
   output logic [4:0]  rsp_fired_entry,
   output logic        rsp_timer_class,
   output logic [31:0] rsp_timer_time,
   output logic        rsp_last
);

   // sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_HEAD   = 4'd1;  // add/remove head scan
   localparam logic [3:0] ST_APPLY  = 4'd2;  // commit add/remove
   localparam logic [3:0] ST_ANY    = 4'd3;  // any-entry scan
   localparam logic [3:0] ST_POP    = 4'd4;  // pop scan, one queue
   localparam logic [3:0] ST_POPEND = 4'd5;  // act on pop scan
   localparam logic [3:0] ST_CLS    = 4'd6;  // class head scan
   localparam logic [3:0] ST_CLSEND = 4'd7;  // arm or cancel
   localparam logic [3:0] ST_CAN0   = 4'd8;  // empty: cancel class 0
   localparam logic [3:0] ST_CAN1   = 4'd9;
   localparam logic [3:0] ST_DONE   = 4'd10;

   slot_type slot_mem [ENTRIES];
   slot_type rd_ff;
   logic [ENTRIES-1:0] valid_ff, valid_in;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  kind_ff;
   logic [4:0]  ent_ff;
   logic [31:0] st_ff, now_ff;
   logic        loc_ff, wk_ff;
   logic [15:0] cnt_ff, cnt_in;
   logic [1:0]  armed_ff, armed_in;
   logic [31:0] atime_ff [2];
   logic [31:0] atime_in [2];
   logic signed [16:0] off_ff;
   logic        offv_ff;

   // scan
   logic [SLOT_W:0] idx_ff, idx_in;     // read address counter
   logic [SLOT_W:0] ridx_ff;             // slot of rd_ff, ENTRIES when none
   logic        rvalid_ff;
   logic        qloc_ff, qloc_in;        // queue being popped / queue of the removed slot
   logic        cls_ff, cls_in;          // class being handled
   logic        best_ok_ff, best_ok_in;
   logic [4:0]  best_ff, best_in;
   logic [31:0] btime_ff, btime_in;
   logic [15:0] bage_ff, bage_in;
   logic        bwake_ff, bwake_in;
   logic        lbest_ok_ff, lbest_ok_in;  // local head for class scan
   logic [31:0] ltime_ff, ltime_in;
   logic [15:0] lage_ff, lage_in;
   logic        flag_ff, flag_in;        // not head / any_utc
   logic        flag2_ff, flag2_in;      // any_loc
   logic [15:0] sage_ff, sage_in;        // removed slot age

   logic        o_v; logic [1:0] o_k; logic [4:0] o_e; logic o_c; logic [31:0] o_t;
   logic        o_last;

   logic [4:0]  widx;
   logic        we;
   slot_type    wdata;

   assign busy = (state_ff != ST_IDLE);

   // memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (we) slot_mem[widx] <= wdata;
      rd_ff <= slot_mem[idx_ff[SLOT_W-1:0]];
   end

   logic [15:0] cur_age;
   logic [31:0] poplim;
   logic [31:0] lconv;
   logic        rv;
   assign rv = rvalid_ff && valid_ff[ridx_ff[SLOT_W-1:0]];
   assign cur_age = cnt_ff - rd_ff.order;
   assign poplim = qloc_ff ? sat32(34'(signed'({2'b00, now_ff})) + 34'(off_ff)) : now_ff;
   assign lconv = sat32(34'(signed'({2'b00, ltime_ff})) - 34'(off_ff));

   always_comb begin
      logic better, lbetter, last_scan;
      logic [31:0] nxt; logic fnd;
      state_in = state_ff; valid_in = valid_ff; cnt_in = cnt_ff; armed_in = armed_ff;
      atime_in = atime_ff; idx_in = idx_ff; qloc_in = qloc_ff; cls_in = cls_ff;
      best_ok_in = best_ok_ff; best_in = best_ff; btime_in = btime_ff; bage_in = bage_ff;
      bwake_in = bwake_ff; lbest_ok_in = lbest_ok_ff; ltime_in = ltime_ff;
      lage_in = lage_ff; flag_in = flag_ff; flag2_in = flag2_ff; sage_in = sage_ff;
      o_v = 1'b0; o_k = RES_NOTHING; o_e = '0; o_c = 1'b0; o_t = '0; o_last = 1'b0;
      we = 1'b0; widx = ent_ff; wdata = '{tim: st_ff, loc: loc_ff, wake: wk_ff, order: cnt_ff};
      better = 1'b0; lbetter = 1'b0; nxt = '0; fnd = 1'b0;
      last_scan = rvalid_ff && (ridx_ff == (SLOT_W+1)'(ENTRIES-1));
      if (idx_ff < (SLOT_W+1)'(ENTRIES)) idx_in = idx_ff + (SLOT_W+1)'(1);

      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (start) begin
               case (req_kind)
                  KIND_ADD, KIND_REMOVE: state_in = ST_HEAD;
                  KIND_WAKE: begin armed_in = 2'b00; state_in = ST_ANY; end
                  default: state_in = ST_ANY;
               endcase
               flag_in = 1'b0; flag2_in = 1'b0; sage_in = '0;
               if (req_kind == KIND_ADD && valid_ff[req_entry])
                  state_in = ST_DONE;
               if (req_kind == KIND_REMOVE && !valid_ff[req_entry])
                  state_in = ST_DONE;
               if (req_kind == KIND_REMOVE) idx_in = {1'b0, req_entry};
            end
         end
         ST_HEAD: begin
            // remove: first read is the slot itself, then a full sweep
            if (kind_ff == KIND_ADD) begin
               if (rv && rd_ff.loc == loc_ff && rd_ff.wake == wk_ff && rd_ff.tim <= st_ff)
                  flag_in = 1'b1;
               if (last_scan) state_in = ST_APPLY;
            end else begin
               if (!flag2_ff) begin
                  if (rvalid_ff) begin
                     flag2_in = 1'b1;
                     btime_in = rd_ff.tim; bwake_in = rd_ff.wake; qloc_in = rd_ff.loc;
                     sage_in = cur_age; idx_in = '0;
                  end else begin
                     // single read of the slot: park the counter until the sweep
                     idx_in = (SLOT_W+1)'(ENTRIES);
                  end
               end else begin
                  if (rv && ridx_ff[4:0] != ent_ff && rd_ff.loc == qloc_ff &&
                      rd_ff.wake == bwake_ff &&
                      (rd_ff.tim < btime_ff || (rd_ff.tim == btime_ff && cur_age > sage_ff)))
                     flag_in = 1'b1;
                  if (last_scan) state_in = ST_APPLY;
               end
            end
         end
         ST_APPLY: begin
            idx_in = '0; flag2_in = 1'b0;
            if (kind_ff == KIND_ADD) begin
               we = 1'b1; valid_in[ent_ff] = 1'b1; cnt_in = cnt_ff + 16'd1;
            end else valid_in[ent_ff] = 1'b0;
            state_in = flag_ff ? ST_DONE : ST_ANY;
            flag_in = 1'b0;
         end
         ST_ANY: begin
            if (rv) begin
               if (rd_ff.loc) flag2_in = 1'b1; else flag_in = 1'b1;
            end
            if (last_scan) begin
               idx_in = '0; best_ok_in = 1'b0; qloc_in = 1'b0;
               if (!flag_in && !(offv_ff && flag2_in)) state_in = ST_CAN0;
               else state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (rv && rd_ff.loc == qloc_ff && rd_ff.tim <= poplim) begin
               better = !best_ok_ff || rd_ff.tim < btime_ff ||
                        (rd_ff.tim == btime_ff && cur_age > bage_ff);
               if (better) begin
                  best_ok_in = 1'b1; best_in = ridx_ff[4:0]; btime_in = rd_ff.tim;
                  bage_in = cur_age; bwake_in = rd_ff.wake;
               end
            end
            if (last_scan) state_in = ST_POPEND;
         end
         ST_POPEND: begin
            idx_in = '0; best_ok_in = 1'b0; lbest_ok_in = 1'b0;
            if (best_ok_ff) begin
               valid_in[best_ff] = 1'b0;
               o_v = 1'b1; o_k = RES_FIRED; o_e = best_ff; o_c = bwake_ff;
               state_in = ST_POP;
            end else if (!qloc_ff && offv_ff) begin
               qloc_in = 1'b1; state_in = ST_POP;
            end else begin
               cls_in = 1'b1; state_in = ST_CLS;
            end
         end
         ST_CLS: begin
            if (rv && rd_ff.wake == cls_ff) begin
               if (!rd_ff.loc) begin
                  better = !best_ok_ff || rd_ff.tim < btime_ff ||
                           (rd_ff.tim == btime_ff && cur_age > bage_ff);
                  if (better) begin
                     best_ok_in = 1'b1; btime_in = rd_ff.tim; bage_in = cur_age;
                  end
               end else begin
                  lbetter = !lbest_ok_ff || rd_ff.tim < ltime_ff ||
                            (rd_ff.tim == ltime_ff && cur_age > lage_ff);
                  if (lbetter) begin
                     lbest_ok_in = 1'b1; ltime_in = rd_ff.tim; lage_in = cur_age;
                  end
               end
            end
            if (last_scan) state_in = ST_CLSEND;
         end
         ST_CLSEND: begin
            fnd = best_ok_ff; nxt = btime_ff;
            if (offv_ff && lbest_ok_ff && (!fnd || lconv < nxt)) begin
               fnd = 1'b1; nxt = lconv;
            end
            if (!fnd) begin
               if (armed_ff[cls_ff]) begin
                  o_v = 1'b1; o_k = RES_CANCEL; o_c = cls_ff; armed_in[cls_ff] = 1'b0;
               end
            end else if (!armed_ff[cls_ff] || nxt != atime_ff[cls_ff]) begin
               o_v = 1'b1; o_k = RES_ARM; o_c = cls_ff; o_t = nxt;
               armed_in[cls_ff] = 1'b1; atime_in[cls_ff] = nxt;
            end
            idx_in = '0; best_ok_in = 1'b0; lbest_ok_in = 1'b0;
            if (cls_ff) begin cls_in = 1'b0; state_in = ST_CLS; end
            else state_in = ST_DONE;
         end
         ST_CAN0: begin
            if (armed_ff[0]) begin
               o_v = 1'b1; o_k = RES_CANCEL; o_c = 1'b0; armed_in[0] = 1'b0;
            end
            state_in = ST_CAN1;
         end
         ST_CAN1: begin
            if (armed_ff[1]) begin
               o_v = 1'b1; o_k = RES_CANCEL; o_c = 1'b1; armed_in[1] = 1'b0;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // close the transaction: flag last on the held result, or give "nothing"
            o_last = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // one result of delay so the final one can carry last
   logic        hv_ff; logic [1:0] hk_ff; logic [4:0] he_ff; logic hc_ff; logic [31:0] ht_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; valid_ff <= '0; cnt_ff <= '0; armed_ff <= '0;
         atime_ff[0] <= '0; atime_ff[1] <= '0; off_ff <= '0; offv_ff <= 1'b0;
         rvalid_ff <= 1'b0; hv_ff <= 1'b0; rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in; cnt_ff <= cnt_in;
         armed_ff <= armed_in; atime_ff <= atime_in;
         rvalid_ff <= (idx_ff < (SLOT_W+1)'(ENTRIES)) && state_ff != ST_IDLE;
         if (csr_write) begin
            if (csr_index == CSR_OFFSET) off_ff <= csr_data;
            else offv_ff <= csr_data[0];
         end
         // the held result leaves when the next one arrives or the transaction closes
         rsp_valid <= o_last || (o_v && hv_ff);
         if (o_last) hv_ff <= 1'b0;
         else if (o_v) hv_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      ridx_ff <= idx_ff;
      idx_ff <= idx_in; qloc_ff <= qloc_in; cls_ff <= cls_in;
      best_ok_ff <= best_ok_in; best_ff <= best_in; btime_ff <= btime_in;
      bage_ff <= bage_in; bwake_ff <= bwake_in; lbest_ok_ff <= lbest_ok_in;
      ltime_ff <= ltime_in; lage_ff <= lage_in; flag_ff <= flag_in;
      flag2_ff <= flag2_in; sage_ff <= sage_in;
      if (state_ff == ST_IDLE && start) begin
         kind_ff <= req_kind; ent_ff <= req_entry; st_ff <= req_start_time;
         loc_ff <= req_is_local; wk_ff <= req_needs_wake; now_ff <= req_now;
      end
      if (o_v) begin
         hk_ff <= o_k; he_ff <= o_e; hc_ff <= o_c; ht_ff <= o_t;
         rsp_kind_res <= hk_ff; rsp_fired_entry <= he_ff;
         rsp_timer_class <= hc_ff; rsp_timer_time <= ht_ff; rsp_last <= 1'b0;
      end
      if (o_last) begin
         rsp_last <= 1'b1;
         if (hv_ff) begin
            rsp_kind_res <= hk_ff; rsp_fired_entry <= he_ff;
            rsp_timer_class <= hc_ff; rsp_timer_time <= ht_ff;
         end else begin
            rsp_kind_res <= RES_NOTHING; rsp_fired_entry <= '0;
            rsp_timer_class <= 1'b0; rsp_timer_time <= '0;
         end
      end
   end
endmodule

// ===== tb/two_clock_expiry_timer_queue_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the expiry timer queue.
// Needs tcetq_pkg and two_clock_expiry_timer_queue; no other files.
module two_clock_expiry_timer_queue_tb
   import tcetq_pkg::*;
();

   // one expected or observed result transaction
   typedef struct packed {
      logic [1:0]  kind_res;
      logic [4:0]  fired_entry;
      logic        timer_class;
      logic [31:0] timer_time;
      logic        last;
   } timer_result_type;

   localparam int CYCLE_LIMIT = 2000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_kind = KIND_TICK;
   logic [4:0]  req_entry = '0;
   logic [31:0] req_start_time = '0;
   logic        req_is_local = 1'b0;
   logic        req_needs_wake = 1'b0;
   logic [31:0] req_now = '0;
   logic        csr_write = 1'b0;
   logic [0:0]  csr_index = CSR_OFFSET;
   logic [16:0] csr_data = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_kind_res;
   logic [4:0]  rsp_fired_entry;
   logic        rsp_timer_class;
   logic [31:0] rsp_timer_time;
   logic        rsp_last;

   two_clock_expiry_timer_queue dut (.*);

   // free-running clock, 10 ns period
   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Shadow copy of the block's state, updated as each transaction
   // is accepted.
   // ---------------------------------------------------------------
   logic        sh_valid [ENTRIES];
   logic [31:0] sh_time  [ENTRIES];
   logic        sh_local [ENTRIES];
   logic        sh_wake  [ENTRIES];
   logic [15:0] sh_order [ENTRIES];
   logic [15:0] sh_counter;
   logic        sh_armed [2];
   logic [31:0] sh_armed_time [2];
   logic signed [16:0] sh_offset;
   logic        sh_offset_ok;

   timer_result_type pending_results[$];
   int  fail_count = 0;
   int  cycle_count = 0;
   bit  idle_enabled = 1'b1;

   // 64-bit signed value clamped to the 32-bit unsigned range
   function automatic logic [31:0] clamp32(input longint v);
      if (v < 0) return '0;
      if (v > 64'sd4294967295) return '1;
      return v[31:0];
   endfunction

   // slot a ahead of slot b: earlier time, then older insertion
   function automatic bit ahead_of(input int a, input int b);
      logic [15:0] age_a, age_b;
      age_a = sh_counter - sh_order[a];
      age_b = sh_counter - sh_order[b];
      if (sh_time[a] != sh_time[b]) return sh_time[a] < sh_time[b];
      return age_a > age_b;
   endfunction

   function automatic void push_result(input logic [1:0] k, input int slot,
                                       input logic cls, input logic [31:0] t);
      timer_result_type r;
      r.kind_res = k;
      r.fired_entry = slot[4:0];
      r.timer_class = cls;
      r.timer_time = t;
      r.last = 1'b0;
      pending_results.push_back(r);
   endfunction

   function automatic void pop_due(input logic loc, input logic [31:0] limit);
      int best;
      forever begin
         best = -1;
         for (int i = 0; i < ENTRIES; i++)
            if (sh_valid[i] && sh_local[i] == loc && sh_time[i] <= limit)
               if (best < 0 || ahead_of(i, best)) best = i;
         if (best < 0) return;
         sh_valid[best] = 1'b0;
         push_result(RES_FIRED, best, sh_wake[best], '0);
      end
   endfunction

   function automatic int queue_head(input logic loc, input logic wk);
      int best;
      best = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (sh_valid[i] && sh_local[i] == loc && sh_wake[i] == wk)
            if (best < 0 || ahead_of(i, best)) best = i;
      return best;
   endfunction

   function automatic void rearm_class(input int c);
      int h, l;
      bit found;
      logic [31:0] nxt, nl;
      found = 0;
      nxt = '0;
      h = queue_head(1'b0, c[0]);
      if (h >= 0) begin
         nxt = sh_time[h];
         found = 1;
      end
      if (sh_offset_ok) begin
         l = queue_head(1'b1, c[0]);
         if (l >= 0) begin
            nl = clamp32(longint'(sh_time[l]) - longint'(sh_offset));
            if (!found || nl < nxt) begin
               nxt = nl;
               found = 1;
            end
         end
      end
      if (!found) begin
         if (sh_armed[c]) begin
            push_result(RES_CANCEL, 0, c[0], '0);
            sh_armed[c] = 1'b0;
         end
      end else if (!sh_armed[c] || nxt != sh_armed_time[c]) begin
         push_result(RES_ARM, 0, c[0], nxt);
         sh_armed_time[c] = nxt;
         sh_armed[c] = 1'b1;
      end
   endfunction

   function automatic void run_scheduler(input logic [31:0] now);
      bit any_utc, any_loc;
      any_utc = 0;
      any_loc = 0;
      for (int i = 0; i < ENTRIES; i++)
         if (sh_valid[i]) begin
            if (sh_local[i]) any_loc = 1;
            else any_utc = 1;
         end
      if (!any_utc && (!sh_offset_ok || !any_loc)) begin
         for (int c = 0; c < 2; c++)
            if (sh_armed[c]) begin
               push_result(RES_CANCEL, 0, c[0], '0);
               sh_armed[c] = 1'b0;
            end
         return;
      end
      pop_due(1'b0, now);
      if (sh_offset_ok) pop_due(1'b1, clamp32(longint'(now) + longint'(sh_offset)));
      rearm_class(1);
      rearm_class(0);
   endfunction

   // work out the results of one accepted command
   function automatic void predict_command(input logic [1:0] kind, input logic [4:0] slot,
                                           input logic [31:0] st, input logic loc,
                                           input logic wk, input logic [31:0] now);
      int n0, s;
      bit head;
      n0 = pending_results.size();
      s = slot;
      head = 1;
      case (kind)
         KIND_ADD: begin
            if (!sh_valid[s]) begin
               for (int i = 0; i < ENTRIES; i++)
                  if (sh_valid[i] && sh_local[i] == loc && sh_wake[i] == wk &&
                      sh_time[i] <= st) head = 0;
               sh_valid[s] = 1'b1;
               sh_time[s] = st;
               sh_local[s] = loc;
               sh_wake[s] = wk;
               sh_order[s] = sh_counter;
               sh_counter++;
               if (head) run_scheduler(now);
            end
         end
         KIND_REMOVE: begin
            if (sh_valid[s]) begin
               for (int i = 0; i < ENTRIES; i++)
                  if (i != s && sh_valid[i] && sh_local[i] == sh_local[s] &&
                      sh_wake[i] == sh_wake[s] && ahead_of(i, s)) head = 0;
               sh_valid[s] = 1'b0;
               if (head) run_scheduler(now);
            end
         end
         KIND_TICK: run_scheduler(now);
         default: begin
            sh_armed[0] = 1'b0;
            sh_armed[1] = 1'b0;
            run_scheduler(now);
         end
      endcase
      if (pending_results.size() == n0) push_result(RES_NOTHING, 0, 1'b0, '0);
      pending_results[$].last = 1'b1;
   endfunction

   // result checker: results cannot be held off, so sample every edge
   always @(posedge clock) begin
      timer_result_type exp_r;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction kind_res=%0d", rsp_kind_res);
            fail_count = fail_count + 1;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_kind_res !== exp_r.kind_res) begin
               $error("kind_res exp %0d got %0d", exp_r.kind_res, rsp_kind_res);
               fail_count = fail_count + 1;
            end
            if (rsp_fired_entry !== exp_r.fired_entry) begin
               $error("fired_entry exp %0d got %0d", exp_r.fired_entry, rsp_fired_entry);
               fail_count = fail_count + 1;
            end
            if (rsp_timer_class !== exp_r.timer_class) begin
               $error("timer_class exp %0d got %0d", exp_r.timer_class, rsp_timer_class);
               fail_count = fail_count + 1;
            end
            if (rsp_timer_time !== exp_r.timer_time) begin
               $error("timer_time exp %0d got %0d", exp_r.timer_time, rsp_timer_time);
               fail_count = fail_count + 1;
            end
            if (rsp_last !== exp_r.last) begin
               $error("last exp %0d got %0d", exp_r.last, rsp_last);
               fail_count = fail_count + 1;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** two_clock_expiry_timer_queue: FAILED **");
         $finish;
      end
   end

   // send one command transaction; holds start until accepted
   task automatic send_command(input logic [1:0] kind, input logic [4:0] slot,
                               input logic [31:0] st, input logic loc,
                               input logic wk, input logic [31:0] now);
      int gap;
      if (idle_enabled && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 13);
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_entry <= slot;
      req_start_time <= st;
      req_is_local <= loc;
      req_needs_wake <= wk;
      req_now <= now;
      @(posedge clock);
      while (busy) @(posedge clock);
      // accepted at this edge
      predict_command(kind, slot, st, loc, wk, now);
      start <= 1'b0;
      // the block is busy for at least this cycle, so no start is lost
      @(posedge clock);
   endtask

   // wait until the block has drained, then a further idle margin
   task automatic drain_results();
      @(posedge clock);
      while (pending_results.size() != 0 || busy) @(posedge clock);
      repeat (4 * (ENTRIES + 1) + 20) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [16:0] val);
      drain_results();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_OFFSET) sh_offset = val;
      else sh_offset_ok = val[0];
   endtask

   // pick a time near a moving base so that entries actually fall due
   function automatic logic [31:0] near_time(input logic [31:0] base);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return $urandom;
         default: return base + $urandom_range(0, 400) - 200;
      endcase
   endfunction

   // directed: extremes of fields, every command, empty and occupied slots
   task automatic test_directed();
      send_command(KIND_TICK, 5'd0, 32'd0, 1'b0, 1'b0, 32'd0);          // empty queues
      send_command(KIND_REMOVE, 5'd5, 32'd0, 1'b0, 1'b0, 32'd0);        // empty slot
      send_command(KIND_ADD, 5'd0, 32'd100, 1'b0, 1'b0, 32'd10);        // new head
      send_command(KIND_ADD, 5'd0, 32'd50, 1'b0, 1'b1, 32'd10);         // occupied
      send_command(KIND_ADD, 5'd31, 32'd100, 1'b0, 1'b0, 32'd10);       // tie, not head
      send_command(KIND_ADD, 5'd1, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'd0);   // wake, max time
      send_command(KIND_ADD, 5'd2, 32'd200, 1'b1, 1'b1, 32'd0);         // local, no offset
      send_command(KIND_REMOVE, 5'd31, 32'd0, 1'b0, 1'b0, 32'd0);       // non-head remove
      send_command(KIND_TICK, 5'd0, 32'd0, 1'b0, 1'b0, 32'd100);        // fires slot 0
      send_command(KIND_WAKE, 5'd0, 32'd0, 1'b0, 1'b0, 32'd100);        // re-arm after wake
      write_csr(CSR_OFFSET, 17'h13B20);                                 // -50400
      write_csr(CSR_VALID, 17'd1);
      send_command(KIND_TICK, 5'd0, 32'd0, 1'b0, 1'b0, 32'd0);          // local counted now
      send_command(KIND_ADD, 5'd3, 32'd0, 1'b1, 1'b0, 32'hFFFF_FFFF);
      send_command(KIND_ADD, 5'd4, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd5);
      write_csr(CSR_OFFSET, 17'd50400);
      send_command(KIND_TICK, 5'd0, 32'd0, 1'b0, 1'b0, 32'hFFFF_FFFF);  // saturated
      send_command(KIND_REMOVE, 5'd1, 32'd0, 1'b0, 1'b0, 32'd0);
      send_command(KIND_WAKE, 5'd0, 32'd0, 1'b0, 1'b0, 32'd0);
      write_csr(CSR_VALID, 17'd0);
      write_csr(CSR_OFFSET, 17'd0);
   endtask

   task automatic test_random(input int count, input bit with_idle);
      logic [31:0] base;
      logic [1:0] k;
      int sel;
      idle_enabled = with_idle;
      base = $urandom_range(1000, 100000);
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 9);
         if (sel < 5) k = KIND_ADD;
         else if (sel < 7) k = KIND_REMOVE;
         else if (sel < 9) k = KIND_TICK;
         else k = KIND_WAKE;
         if ($urandom_range(0, 3) == 0) base = base + $urandom_range(0, 150);
         send_command(k, 5'($urandom_range(0, ENTRIES - 1)), near_time(base),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      ($urandom_range(0, 19) == 0) ? 32'($urandom) : base);
      end
   endtask

   task automatic test_config_sweep();
      write_csr(CSR_OFFSET, 17'($urandom_range(0, 400)) - 17'd200);
      write_csr(CSR_VALID, 17'd1);
      test_random(40, 1'b1);
      write_csr(CSR_OFFSET, 17'($signed(-17'sd50400)));
      test_random(20, 1'b1);
      write_csr(CSR_OFFSET, 17'd50400);
      write_csr(CSR_VALID, 17'd0);
      test_random(20, 1'b1);
      write_csr(CSR_VALID, 17'd1);
      write_csr(CSR_OFFSET, 17'($urandom_range(0, 100800)) - 17'd50400);
      test_random(20, 1'b0);                               // no idling at the end
   endtask

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         sh_valid[i] = 0;
         sh_time[i] = '0;
         sh_local[i] = 0;
         sh_wake[i] = 0;
         sh_order[i] = '0;
      end
      sh_counter = '0;
      sh_armed[0] = 0;
      sh_armed[1] = 0;
      sh_armed_time[0] = '0;
      sh_armed_time[1] = '0;
      sh_offset = '0;
      sh_offset_ok = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(20, 1'b1);
      test_config_sweep();
      drain_results();
      if (fail_count == 0 && pending_results.size() == 0)
         $display("** two_clock_expiry_timer_queue: PASSED **");
      else
         $display("** two_clock_expiry_timer_queue: FAILED **");
      $finish;
   end
endmodule
